// ----- src/pvrs_pkg.sv -----
package pvrs_pkg;

   localparam int NUM_VECTORS  = 2;
   localparam int CORDIC_STEPS = 16;

   localparam int IDX_W  = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int CW     = 28;
   localparam int MB_W   = 31;
   localparam int PROD_W = CW + MB_W;
   localparam int ACC_W  = 34;
   localparam int OFS_W  = 20;
   localparam int SUM_W  = 21;

   localparam logic signed [MB_W-1:0] CORDIC_KINV = 31'sd652032874;

   localparam logic signed [15:0] ENDPOINT_RESET    = 16'sd800;
   localparam logic [14:0]        CENTER_X_RESET    = 15'd8000;
   localparam logic [14:0]        CENTER_Y_RESET    = 15'd4000;
   localparam logic [14:0]        LENGTH_STEP_RESET = 15'd80;
   localparam logic signed [15:0] ROTATE_COS_RESET  = 16'sd16362;
   localparam logic signed [15:0] ROTATE_SIN_RESET  = 16'sd857;

   typedef enum logic [1:0] {
      OP_LENGTHEN,
      OP_SHORTEN,
      OP_ROT_POS,
      OP_ROT_NEG
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_CENTER_X,
      CSR_CENTER_Y,
      CSR_LENGTH_STEP,
      CSR_ROTATE_COS,
      CSR_ROTATE_SIN
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_VECTOR,
      ST_GAIN_A,
      ST_LENGTH,
      ST_GAIN_B,
      ST_ROT_LOAD,
      ST_ROTATE,
      ST_ROUND_S,
      ST_PROD,
      ST_PROD_LAST,
      ST_ROUND_R,
      ST_DONE
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [15:0] r;
      if (v > SUM_W'(32767)) begin
         r = 16'sd32767;
      end else if (v < -SUM_W'(32768)) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- src/polar_vector_rotate_and_stretch.sv -----
// Channel   Ports                                      Transfer when
// request   start, busy, req_vector_index, req_opcode  start && !busy
// response  rsp_valid, rsp_end_x, rsp_end_y            rsp_valid (one cycle, no stall)
// config    csr_valid, csr_ready, csr_index, csr_data  csr_valid && csr_ready
//
// Rotate: four products from the shared multiplier are accumulated and rounded before rsp_valid.
// Lengthen/shorten: the shared shift-add CORDIC stage is used once per step for vectoring
// and again for rotation; a zero offset skips both passes.
// busy stays high until the result is out; the next request may follow in the rsp_valid cycle.
// Synchronous reset restores the configuration and all endpoints; csr_ready is always high.
module polar_vector_rotate_and_stretch
   import pvrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [0:0]         req_vector_index,
   input  logic [1:0]         req_opcode,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_end_x,
   output logic signed [15:0] rsp_end_y,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   state_type state_ff, state_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   opcode_type       op_ff, op_in;

   logic [14:0]        center_x_ff, center_y_ff, length_step_ff;
   logic signed [15:0] rotate_cos_ff, rotate_sin_ff;

   logic signed [15:0] endpoint_x_ff [NUM_VECTORS];
   logic signed [15:0] endpoint_y_ff [NUM_VECTORS];

   logic signed [16:0]       ox_ff, ox_in, oy_ff, oy_in;
   logic signed [CW-1:0]     x_ff, x_in, y_ff, y_in;
   logic [CORDIC_STEPS-1:0]  dirs_ff, dirs_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     flip_ff, flip_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [1:0]               phase_ff, phase_in;
   logic signed [OFS_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic signed [15:0]       ep_x_sel, ep_y_sel;
   logic signed [16:0]       ox_c, oy_c, ox_abs, oy_abs;
   logic signed [15:0]       delta_c;
   logic signed [CW-1:0]     delta_sh;
   logic signed [16:0]       s_eff;
   logic signed [CW-1:0]     xs, ys;
   logic                     sub_mode;
   logic                     step_last;
   logic signed [CW-1:0]     mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] mul_out;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [CW-1:0]     gain_c;
   logic [1:0]               acc_phase;
   logic signed [ACC_W-1:0]  prod_acc;
   logic signed [CW-1:0]     x_rnd, y_rnd;
   logic signed [OFS_W-1:0]  xr, yr;
   logic signed [ACC_W-1:0]  accx_rnd, accy_rnd;
   logic signed [SUM_W-1:0]  sum_x, sum_y;
   logic signed [15:0]       ex_c, ey_c;

   assign ep_x_sel = endpoint_x_ff[idx_ff];
   assign ep_y_sel = endpoint_y_ff[idx_ff];
   assign ox_c     = 17'(ep_x_sel) - signed'({2'b00, center_x_ff});
   assign oy_c     = 17'(ep_y_sel) - signed'({2'b00, center_y_ff});
   assign ox_abs   = ox_c[16] ? -ox_c : ox_c;
   assign oy_abs   = ox_c[16] ? -oy_c : oy_c;

   assign delta_c  = (op_ff == OP_LENGTHEN) ? signed'({1'b0, length_step_ff})
                                            : -signed'({1'b0, length_step_ff});
   assign delta_sh = CW'(delta_c) <<< 8;
   assign s_eff    = (op_ff == OP_ROT_NEG) ? -17'(rotate_sin_ff) : 17'(rotate_sin_ff);

   assign xs        = x_ff >>> step_ff;
   assign ys        = y_ff >>> step_ff;
   assign sub_mode  = (state_ff == ST_VECTOR) ? !y_ff[CW-1] : !dirs_ff[step_ff];
   assign step_last = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   always_comb begin
      mul_a = x_ff;
      mul_b = CORDIC_KINV;
      if (state_ff == ST_PROD) begin
         case (phase_ff)
            2'd0: begin
               mul_a = CW'(ox_ff);
               mul_b = MB_W'(rotate_cos_ff);
            end
            2'd1: begin
               mul_a = CW'(oy_ff);
               mul_b = MB_W'(s_eff);
            end
            2'd2: begin
               mul_a = CW'(ox_ff);
               mul_b = MB_W'(s_eff);
            end
            default: begin
               mul_a = CW'(oy_ff);
               mul_b = MB_W'(rotate_cos_ff);
            end
         endcase
      end
   end

   assign mul_out   = mul_a * mul_b;
   assign prod_rnd  = prod_ff + PROD_W'(2 ** 29);
   assign gain_c    = prod_rnd[30 +: CW];
   assign acc_phase = phase_ff - 2'd1;
   assign prod_acc  = prod_ff[ACC_W-1:0];
   assign x_rnd     = x_ff + CW'(128);
   assign y_rnd     = y_ff + CW'(128);
   assign xr        = x_rnd[8 +: OFS_W];
   assign yr        = y_rnd[8 +: OFS_W];
   assign accx_rnd  = acc_x_ff + ACC_W'(2 ** 13);
   assign accy_rnd  = acc_y_ff + ACC_W'(2 ** 13);
   assign sum_x     = signed'({6'b0, center_x_ff}) + SUM_W'(nx_ff);
   assign sum_y     = signed'({6'b0, center_y_ff}) + SUM_W'(ny_ff);
   assign ex_c      = sat16(sum_x);
   assign ey_c      = sat16(sum_y);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      op_in        = op_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dirs_in      = dirs_ff;
      step_in      = step_ff;
      flip_in      = flip_ff;
      prod_in      = prod_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      phase_in     = phase_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      rsp_valid_in = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in   = (NUM_VECTORS > 1) ? IDX_W'(req_vector_index) : '0;
               op_in    = opcode_type'(req_opcode);
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            ox_in = ox_c;
            oy_in = oy_c;
            if (op_ff == OP_ROT_POS || op_ff == OP_ROT_NEG) begin
               acc_x_in = '0;
               acc_y_in = '0;
               phase_in = '0;
               state_in = ST_PROD;
            end else if (ox_c == '0 && oy_c == '0) begin
               nx_in    = OFS_W'(delta_c);
               ny_in    = '0;
               state_in = ST_DONE;
            end else begin
               flip_in  = ox_c[16];
               x_in     = CW'(ox_abs) <<< 8;
               y_in     = CW'(oy_abs) <<< 8;
               step_in  = '0;
               dirs_in  = '0;
               state_in = ST_VECTOR;
            end
         end
         ST_VECTOR, ST_ROTATE: begin
            if (sub_mode) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
            end
            if (state_ff == ST_VECTOR) begin
               dirs_in[step_ff] = sub_mode;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_last) begin
               step_in  = '0;
               state_in = (state_ff == ST_VECTOR) ? ST_GAIN_A : ST_ROUND_S;
            end
         end
         ST_GAIN_A: begin
            prod_in  = mul_out;
            state_in = ST_LENGTH;
         end
         ST_LENGTH: begin
            x_in     = gain_c + delta_sh;
            state_in = ST_GAIN_B;
         end
         ST_GAIN_B: begin
            prod_in  = mul_out;
            state_in = ST_ROT_LOAD;
         end
         ST_ROT_LOAD: begin
            x_in     = gain_c;
            y_in     = '0;
            step_in  = '0;
            state_in = ST_ROTATE;
         end
         ST_ROUND_S: begin
            nx_in    = flip_ff ? -xr : xr;
            ny_in    = flip_ff ? -yr : yr;
            state_in = ST_DONE;
         end
         ST_PROD, ST_PROD_LAST: begin
            if (state_ff == ST_PROD) begin
               prod_in  = mul_out;
               phase_in = phase_ff + 2'd1;
            end
            if (state_ff == ST_PROD_LAST || phase_ff != 2'd0) begin
               case (acc_phase)
                  2'd0:    acc_x_in = acc_x_ff + prod_acc;
                  2'd1:    acc_x_in = acc_x_ff - prod_acc;
                  default: acc_y_in = acc_y_ff + prod_acc;
               endcase
            end
            if (state_ff == ST_PROD_LAST) begin
               state_in = ST_ROUND_R;
            end else if (phase_ff == 2'd3) begin
               state_in = ST_PROD_LAST;
            end
         end
         ST_ROUND_R: begin
            nx_in    = accx_rnd[14 +: OFS_W];
            ny_in    = accy_rnd[14 +: OFS_W];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = ex_c;
            rsp_y_in     = ey_c;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      op_ff    <= op_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      dirs_ff  <= dirs_in;
      step_ff  <= step_in;
      flip_ff  <= flip_in;
      prod_ff  <= prod_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      phase_ff <= phase_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VECTORS; i++) begin
            endpoint_x_ff[i] <= ENDPOINT_RESET;
            endpoint_y_ff[i] <= ENDPOINT_RESET;
         end
      end else if (state_ff == ST_DONE) begin
         endpoint_x_ff[idx_ff] <= ex_c;
         endpoint_y_ff[idx_ff] <= ey_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= CENTER_X_RESET;
         center_y_ff    <= CENTER_Y_RESET;
         length_step_ff <= LENGTH_STEP_RESET;
         rotate_cos_ff  <= ROTATE_COS_RESET;
         rotate_sin_ff  <= ROTATE_SIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_X:    center_x_ff    <= csr_data[14:0];
            CSR_CENTER_Y:    center_y_ff    <= csr_data[14:0];
            CSR_LENGTH_STEP: length_step_ff <= csr_data[14:0];
            CSR_ROTATE_COS:  rotate_cos_ff  <= signed'(csr_data);
            CSR_ROTATE_SIN:  rotate_sin_ff  <= signed'(csr_data);
            default: begin
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_end_x = rsp_x_ff;
   assign rsp_end_y = rsp_y_ff;
   assign csr_ready = 1'b1;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted without going busy");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (rsp_valid && !busy))
      else $error("finished item did not produce a response");

   a_rsp_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_x == endpoint_x_ff[idx_ff] && rsp_end_y == endpoint_y_ff[idx_ff]))
      else $error("response differs from stored endpoint");

   a_rot_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT_LOAD) |=> (state_ff == ST_ROTATE && y_ff == '0 && step_ff == '0))
      else $error("rotation pass started from a bad state");

endmodule

// ----- tb/pvrs_checker.sv -----
`timescale 1ns / 100ps

module pvrs_checker
   import pvrs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [0:0]         req_vector_index,
   input  logic [1:0]         req_opcode,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_end_x,
   input  logic signed [15:0] rsp_end_y,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 mismatches,
   output int                 outstanding,
   output int                 checked
);

   localparam longint GAIN_INV   = 64'sd652032874;
   localparam int     GUARD_BITS = 8;

   localparam logic [14:0]        INIT_CENTER_X = 15'd8000;
   localparam logic [14:0]        INIT_CENTER_Y = 15'd4000;
   localparam logic [14:0]        INIT_STEP     = 15'd80;
   localparam logic signed [15:0] INIT_COS      = 16'sd16362;
   localparam logic signed [15:0] INIT_SIN      = 16'sd857;
   localparam logic signed [15:0] INIT_POS      = 16'sd800;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } endpoint_type;

   endpoint_type       pending_ends[$];
   logic signed [15:0] pos_x [NUM_VECTORS];
   logic signed [15:0] pos_y [NUM_VECTORS];
   logic [14:0]        ctr_x;
   logic [14:0]        ctr_y;
   logic [14:0]        step_len;
   logic signed [15:0] rot_c;
   logic signed [15:0] rot_s;

   function automatic longint round_half_up(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [15:0] clamp_coord(input longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Vector onto the x axis, change the magnitude, rotate back along the same path.
   function automatic void stretch_offset(input longint ox_in, input longint oy_in,
                                          input longint delta,
                                          output longint nx, output longint ny);
      longint      ox;
      longint      oy;
      longint      x;
      longint      y;
      longint      dx;
      longint      dy;
      longint      mag;
      logic [31:0] dirs;
      bit          flip;
      ox   = ox_in;
      oy   = oy_in;
      dirs = '0;
      if (ox == 0 && oy == 0) begin
         nx = delta;
         ny = 0;
         return;
      end
      flip = (ox < 0);
      if (flip) begin
         ox = -ox;
         oy = -oy;
      end
      x = ox <<< GUARD_BITS;
      y = oy <<< GUARD_BITS;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            dirs[i] = 1'b1;
         end else begin
            x = x - dx;
            y = y + dy;
         end
      end
      mag = round_half_up(x * GAIN_INV, 30) + (delta <<< GUARD_BITS);
      x   = round_half_up(mag * GAIN_INV, 30);
      y   = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (dirs[i]) begin
            x = x - dx;
            y = y + dy;
         end else begin
            x = x + dx;
            y = y - dy;
         end
      end
      x  = round_half_up(x, GUARD_BITS);
      y  = round_half_up(y, GUARD_BITS);
      nx = flip ? -x : x;
      ny = flip ? -y : y;
   endfunction

   function automatic endpoint_type predict_move(input logic [0:0] vi, input opcode_type op);
      int           slot;
      longint       ox;
      longint       oy;
      longint       nx;
      longint       ny;
      longint       c;
      longint       s;
      longint       delta;
      endpoint_type res;
      slot = int'(vi) % NUM_VECTORS;
      ox   = longint'(pos_x[slot]) - longint'(ctr_x);
      oy   = longint'(pos_y[slot]) - longint'(ctr_y);
      case (op)
         OP_LENGTHEN, OP_SHORTEN: begin
            delta = longint'(step_len);
            if (op == OP_SHORTEN) begin
               delta = -delta;
            end
            stretch_offset(ox, oy, delta, nx, ny);
         end
         default: begin
            c = longint'(rot_c);
            s = longint'(rot_s);
            if (op == OP_ROT_NEG) begin
               s = -s;
            end
            nx = round_half_up(ox * c - oy * s, 14);
            ny = round_half_up(ox * s + oy * c, 14);
         end
      endcase
      res.x       = clamp_coord(longint'(ctr_x) + nx);
      res.y       = clamp_coord(longint'(ctr_y) + ny);
      pos_x[slot] = res.x;
      pos_y[slot] = res.y;
      return res;
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
         CSR_CENTER_X:    ctr_x    = data[14:0];
         CSR_CENTER_Y:    ctr_y    = data[14:0];
         CSR_LENGTH_STEP: step_len = data[14:0];
         CSR_ROTATE_COS:  rot_c    = data;
         CSR_ROTATE_SIN:  rot_s    = data;
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      endpoint_type want;
      if (reset) begin
         pending_ends.delete();
         ctr_x    = INIT_CENTER_X;
         ctr_y    = INIT_CENTER_Y;
         step_len = INIT_STEP;
         rot_c    = INIT_COS;
         rot_s    = INIT_SIN;
         for (int i = 0; i < NUM_VECTORS; i++) begin
            pos_x[i] = INIT_POS;
            pos_y[i] = INIT_POS;
         end
      end else begin
         if (rsp_valid) begin
            if (pending_ends.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected endpoint transfer, expected none, actual (%0d, %0d)",
                        $time, rsp_end_x, rsp_end_y);
            end else begin
               want = pending_ends.pop_front();
               checked++;
               if (rsp_end_x !== want.x) begin
                  mismatches++;
                  $display("%0t: end_x mismatch, expected %0d, actual %0d",
                           $time, want.x, rsp_end_x);
               end
               if (rsp_end_y !== want.y) begin
                  mismatches++;
                  $display("%0t: end_y mismatch, expected %0d, actual %0d",
                           $time, want.y, rsp_end_y);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
         end
         if (start && !busy) begin
            pending_ends.push_back(predict_move(req_vector_index, opcode_type'(req_opcode)));
         end
      end
      outstanding <= pending_ends.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import pvrs_pkg::*;

   localparam logic [2:0] CSR_UNUSED   = 3'd5;
   localparam int         PHASES       = 10;
   localparam int         PHASE_MOVES  = 110;
   localparam int         SETTLE_CYCLES = 50;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [0:0]         req_vector_index;
   logic [1:0]         req_opcode;
   logic               rsp_valid;
   logic signed [15:0] rsp_end_x;
   logic signed [15:0] rsp_end_y;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;

   logic signed [15:0] last_x;
   logic signed [15:0] last_y;
   logic [0:0]         last_vi;

   int mismatches;
   int outstanding;
   int checked;
   int moves_sent;
   int csr_writes;

   polar_vector_rotate_and_stretch u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_vector_index (req_vector_index),
      .req_opcode       (req_opcode),
      .rsp_valid        (rsp_valid),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   pvrs_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_vector_index (req_vector_index),
      .req_opcode       (req_opcode),
      .rsp_valid        (rsp_valid),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .checked          (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL polar_vector_rotate_and_stretch");
      $finish;
   end

   // Hold the most recent endpoint transfer.
   always @(posedge clock) begin
      if (rsp_valid) begin
         last_x <= rsp_end_x;
         last_y <= rsp_end_y;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 20);
      end
      return $urandom_range(30, 150);
   endfunction

   task automatic send_move(input logic [0:0] vi, input opcode_type op, input int gap);
      start            <= 1'b1;
      req_vector_index <= vi;
      req_opcode       <= op;
      last_vi          = vi;
      @(posedge clock);
      while (busy) @(posedge clock);
      moves_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every endpoint has come back, then let the datapath settle.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
   endtask

   task automatic csr_close();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_csr_value(input logic [2:0] idx);
      int r;
      r = $urandom_range(0, 99);
      case (idx)
         CSR_CENTER_X, CSR_CENTER_Y: begin
            if (r < 10) return 16'h0000;
            if (r < 20) return 16'h7FFF;
            if (r < 35) return 16'($urandom_range(0, 65535));
            return 16'($urandom_range(0, 32767));
         end
         CSR_LENGTH_STEP: begin
            if (r < 10) return 16'h0000;
            if (r < 15) return 16'h7FFF;
            if (r < 25) return 16'($urandom_range(0, 65535));
            return 16'($urandom_range(0, 1500));
         end
         CSR_ROTATE_COS: begin
            if (r < 70) return 16'($urandom_range(14000, 16384));
            if (r < 80) return (r[0]) ? 16'sd16384 : -16'sd16384;
            return 16'($urandom_range(0, 65535));
         end
         default: begin
            if (r < 70) return 16'($signed($urandom_range(0, 16000)) - 8000);
            if (r < 80) return (r[0]) ? 16'sd16384 : -16'sd16384;
            return 16'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   initial begin
      bit quiet;
      int gap;
      reset            = 1'b1;
      start            = 1'b0;
      req_vector_index = '0;
      req_opcode       = OP_LENGTHEN;
      csr_valid        = 1'b0;
      csr_index        = CSR_CENTER_X;
      csr_data         = '0;
      moves_sent       = 0;
      csr_writes       = 0;
      last_vi          = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: both vectors sit in the left half plane.
      send_move(1'b0, OP_LENGTHEN, 0);
      send_move(1'b1, OP_SHORTEN, 2);
      send_move(1'b0, OP_ROT_POS, 0);
      send_move(1'b1, OP_ROT_NEG, 5);

      // Center on top of the endpoint: zero offset, then a shortened zero offset.
      wait_idle();
      csr_write(CSR_CENTER_X, 16'(last_x));
      csr_write(CSR_CENTER_Y, 16'(last_y));
      csr_close();
      send_move(last_vi, OP_LENGTHEN, 0);
      wait_idle();
      csr_write(CSR_CENTER_X, 16'(last_x));
      csr_close();
      csr_write(CSR_CENTER_Y, 16'(last_y));
      csr_close();
      send_move(last_vi, OP_SHORTEN, 0);

      wait_idle();
      csr_write(CSR_LENGTH_STEP, 16'd200);
      csr_close();
      send_move(1'b0, OP_SHORTEN, 0);
      send_move(1'b1, OP_LENGTHEN, 1);
      send_move(1'b1, OP_ROT_POS, 0);
      send_move(1'b0, OP_ROT_NEG, 3);

      // Out of range cosine and sine, center at the top of its range.
      wait_idle();
      csr_write(CSR_ROTATE_COS, 16'h8000);
      csr_write(CSR_ROTATE_SIN, 16'h7FFF);
      csr_write(CSR_CENTER_X, 16'hFFFF);
      csr_close();
      send_move(1'b0, OP_ROT_POS, 0);
      send_move(1'b1, OP_ROT_NEG, 0);

      // Largest step, center at zero, a write to an unused register.
      wait_idle();
      csr_write(CSR_LENGTH_STEP, 16'hFFFF);
      csr_write(CSR_CENTER_X, 16'h0000);
      csr_write(CSR_CENTER_Y, 16'h0000);
      csr_write(CSR_UNUSED, 16'hFFFF);
      csr_close();
      send_move(1'b0, OP_LENGTHEN, 0);
      send_move(1'b1, OP_SHORTEN, 0);
      send_move(1'b0, OP_SHORTEN, 0);
      send_move(1'b1, OP_LENGTHEN, 0);

      wait_idle();
      csr_write(CSR_ROTATE_COS, 16'd16384);
      csr_write(CSR_ROTATE_SIN, 16'hC000);
      csr_write(CSR_LENGTH_STEP, 16'h0000);
      csr_write(CSR_CENTER_X, 16'd16000);
      csr_write(CSR_CENTER_Y, 16'd200);
      csr_close();
      send_move(1'b0, OP_ROT_POS, 0);
      send_move(1'b1, OP_ROT_NEG, 0);
      send_move(1'b0, OP_LENGTHEN, 0);
      send_move(1'b1, OP_SHORTEN, 0);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         for (int k = CSR_CENTER_X; k <= CSR_ROTATE_SIN; k++) begin
            if ($urandom_range(0, 99) < 70) begin
               csr_write(3'(k), random_csr_value(3'(k)));
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            csr_write(3'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)));
         end
         csr_close();
         quiet = (p % 4 == 1);
         for (int n = 0; n < PHASE_MOVES; n++) begin
            gap = quiet ? 0 : pick_gap();
            send_move(1'($urandom_range(0, 1)), opcode_type'($urandom_range(0, 3)), gap);
         end
      end

      wait_idle();
      $display("Checked %0d endpoints from %0d moves across %0d register writes,",
               checked, moves_sent, csr_writes);
      $display("covering zero offsets, mirroring, saturation and %0d random phases.", PHASES);
      if (mismatches == 0 && outstanding == 0 && checked == moves_sent) begin
         $display("PASS polar_vector_rotate_and_stretch");
      end else begin
         $display("FAIL polar_vector_rotate_and_stretch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/pvrs_pkg.sv
src/polar_vector_rotate_and_stretch.sv
tb/pvrs_checker.sv
tb/tb_top.sv
